// ----- src/lpc_pkg.sv -----
// Package for the lidar point covariance block: payload structs, pipeline stage structs,
// lane tables, register indexes and the one-bit restoring division step.
// No dependencies; every other file imports this package.
package lpc_pkg;

    localparam int NUM_LANES = 6;
    localparam int DIV_STEPS = 64;

    localparam logic [31:0] RV_RESET  = 32'd429497;
    localparam logic [31:0] AV_RESET  = 32'd4295;
    localparam logic [46:0] TINY_DIAG = 47'd4295;

    localparam logic [46:0] SAT_POS47 = {47{1'b1}};
    localparam logic [47:0] SAT_POS48 = {1'b0, {47{1'b1}}};
    localparam logic [47:0] SAT_NEG48 = {1'b1, {47{1'b0}}};
    localparam logic [97:0] ROUND_HALF = 98'h8000_0000;

    // Configuration register indexes.
    localparam logic CFG_RANGE_VAR = 1'b0;
    localparam logic CFG_ANGLE_VAR = 1'b1;

    // Lanes in output order: xx, xy, xz, yy, yz, zz.
    localparam logic [1:0] LANE_I [NUM_LANES] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
    localparam logic [1:0] LANE_J [NUM_LANES] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2};
    localparam logic [NUM_LANES-1:0] LANE_DIAG = 6'b101001;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } t_point;

    typedef struct packed {
        logic [46:0]        cov_xx;
        logic signed [47:0] cov_xy;
        logic signed [47:0] cov_xz;
        logic [46:0]        cov_yy;
        logic signed [47:0] cov_yz;
        logic [46:0]        cov_zz;
        logic               degenerate;
    } t_cov;

    typedef struct packed {
        logic [2:0][31:0] mag;
        logic [2:0]       neg;
    } t_s1;

    typedef struct packed {
        logic [2:0][31:0]          mag;
        logic [2:0]                neg;
        logic [NUM_LANES-1:0][63:0] pm;
    } t_s2;

    typedef struct packed {
        logic [2:0][31:0]          mag;
        logic [2:0]                neg;
        logic [63:0]               r2;
        logic [NUM_LANES-1:0][63:0] mlo;
        logic [NUM_LANES-1:0][63:0] mhi;
    } t_s3;

    typedef struct packed {
        logic [2:0][31:0]          mag;
        logic [2:0]                neg;
        logic [63:0]               r2;
        logic [NUM_LANES-1:0][63:0] rem;
        logic [NUM_LANES-1:0][63:0] nq;
    } t_div;

    typedef struct packed {
        logic [2:0]                neg;
        logic [63:0]               r2;
        logic                      degen;
        logic [NUM_LANES-1:0][63:0] pm;
        logic [NUM_LANES-1:0][63:0] q;
        logic [NUM_LANES-1:0]      rnz;
    } t_p1;

    typedef struct packed {
        logic                      degen;
        logic [NUM_LANES-1:0][65:0] qs;
        logic [NUM_LANES-1:0][63:0] qm;
        logic [NUM_LANES-1:0]      qneg;
    } t_p2;

    typedef struct packed {
        logic                      degen;
        logic [NUM_LANES-1:0][65:0] qs;
        logic [NUM_LANES-1:0]      qneg;
        logic [NUM_LANES-1:0][63:0] alo;
        logic [NUM_LANES-1:0][63:0] ahi;
    } t_p3;

    typedef struct packed {
        logic                      degen;
        logic [NUM_LANES-1:0][65:0] qs;
        logic [NUM_LANES-1:0]      qneg;
        logic [NUM_LANES-1:0][95:0] tm;
    } t_p4;

    typedef struct packed {
        logic                      degen;
        logic [NUM_LANES-1:0][97:0] s;
    } t_p5;

    // One quotient bit per lane: shift the next numerator bit into the remainder,
    // subtract the divisor when it fits, and shift the quotient bit in at the bottom.
    function automatic t_div div_step(input t_div d);
        t_div        r;
        logic [64:0] t;
        logic        ge;
        r = d;
        for (int l = 0; l < NUM_LANES; l++) begin
            t  = {d.rem[l], d.nq[l][63]};
            ge = (t >= {1'b0, d.r2});
            r.rem[l] = ge ? 64'(t - {1'b0, d.r2}) : t[63:0];
            r.nq[l]  = {d.nq[l][62:0], ge};
        end
        return r;
    endfunction

endpackage

// ----- src/lidar_point_covariance.sv -----
// Top level of the lidar point covariance block: a 74-stage pipeline that turns one
// Q16.16 point into the six unique entries of its range/bearing covariance.
// Depends on lpc_pkg for payload types, stage structs and the division step.
//
//  Channel | Direction | Signals                               | Transaction
//  --------+-----------+---------------------------------------+-------------------------
//  in      | input     | i_in_valid, o_in_ready, i_in_point    | one point (x, y, z)
//  out     | output    | o_out_valid, i_out_ready, o_out_cov   | one covariance result
//  cfg     | input     | i_cfg_we, i_cfg_index, i_cfg_data     | one register write
//
// One transaction enters per cycle unless the output stalls. The latency is
// set by the range term, which divides a 126-bit numerator by the squared norm with a
// 64-stage restoring divider (one quotient bit per stage, six lanes side by side).
// Reset is synchronous and active low; it clears the valid bits and loads the two
// variance registers with their defaults. A stall at the output freezes every stage at
// once, so nothing is lost or repeated, and the input keeps accepting while the output
// register is empty or being taken.
module lidar_point_covariance (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  lpc_pkg::t_point i_in_point,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output lpc_pkg::t_cov  o_out_cov,
    input  logic           i_cfg_we,
    input  logic           i_cfg_index,
    input  logic [31:0]    i_cfg_data
);
    import lpc_pkg::*;

    logic [31:0] r_rv;
    logic [31:0] r_av;

    logic en;

    logic r_v1, r_v2, r_v3, r_vp1, r_vp2, r_vp3, r_vp4, r_vp5, r_out_v;
    logic [DIV_STEPS:0] r_dv;

    t_s1  r_s1, n_s1;
    t_s2  r_s2, n_s2;
    t_s3  r_s3, n_s3;
    t_div r_div [DIV_STEPS+1];
    t_div n_div0;
    t_p1  r_p1, n_p1;
    t_p2  r_p2, n_p2;
    t_p3  r_p3, n_p3;
    t_p4  r_p4, n_p4;
    t_p5  r_p5, n_p5;
    t_cov r_out, n_out;

    logic [NUM_LANES-1:0][47:0] sat;
    logic [NUM_LANES-1:0][65:0] sh;

    // The whole pipeline moves when the output register is free or being taken.
    assign en          = !r_out_v || i_out_ready;
    assign o_in_ready  = en;
    assign o_out_valid = r_out_v;
    assign o_out_cov   = r_out;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rv <= RV_RESET;
            r_av <= AV_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_RANGE_VAR: r_rv <= i_cfg_data;
                CFG_ANGLE_VAR: r_av <= i_cfg_data;
                default:       r_rv <= r_rv;
            endcase
        end
    end

    // Stage 1: sign and magnitude of each coordinate.
    always_comb begin
        logic [2:0][31:0] raw;
        raw = {i_in_point.point_x, i_in_point.point_y, i_in_point.point_z};
        for (int k = 0; k < 3; k++) begin
            n_s1.neg[2-k] = raw[k][31];
            n_s1.mag[2-k] = raw[k][31] ? (~raw[k] + 32'd1) : raw[k];
        end
    end

    // Stage 2: coordinate products for every lane.
    always_comb begin
        n_s2.mag = r_s1.mag;
        n_s2.neg = r_s1.neg;
        for (int l = 0; l < NUM_LANES; l++) begin
            n_s2.pm[l] = r_s1.mag[LANE_I[l]] * r_s1.mag[LANE_J[l]];
        end
    end

    // Stage 3: squared norm, and the range variance times each product in two halves.
    always_comb begin
        n_s3.mag = r_s2.mag;
        n_s3.neg = r_s2.neg;
        n_s3.r2  = r_s2.pm[0] + r_s2.pm[3] + r_s2.pm[5];
        for (int l = 0; l < NUM_LANES; l++) begin
            n_s3.mlo[l] = r_rv * r_s2.pm[l][31:0];
            n_s3.mhi[l] = r_rv * r_s2.pm[l][63:32];
        end
    end

    // Divider entry. The numerator is (rv*pm) << 32; its top 64 bits are already below
    // the divisor, so they seed the remainder and 64 more bits remain to shift in.
    always_comb begin
        n_div0.mag = r_s3.mag;
        n_div0.neg = r_s3.neg;
        n_div0.r2  = r_s3.r2;
        for (int l = 0; l < NUM_LANES; l++) begin
            n_div0.rem[l] = r_s3.mhi[l] + {32'd0, r_s3.mlo[l][63:32]};
            n_div0.nq[l]  = {r_s3.mlo[l][31:0], 32'd0};
        end
    end

    // After division: quotient, sticky remainder, and the products again for the
    // bearing term.
    always_comb begin
        n_p1.neg   = r_div[DIV_STEPS].neg;
        n_p1.r2    = r_div[DIV_STEPS].r2;
        n_p1.degen = (r_div[DIV_STEPS].r2 == 64'd0);
        for (int l = 0; l < NUM_LANES; l++) begin
            n_p1.pm[l]  = r_div[DIV_STEPS].mag[LANE_I[l]] * r_div[DIV_STEPS].mag[LANE_J[l]];
            n_p1.q[l]   = r_div[DIV_STEPS].nq[l];
            n_p1.rnz[l] = (r_div[DIV_STEPS].rem[l] != 64'd0);
        end
    end

    // Signs. A negative off-diagonal range term rounds its magnitude up before negating,
    // which floors the signed quotient. On the diagonal the bearing factor r2 - p*p is
    // never negative; off the diagonal it carries the opposite sign of the product.
    always_comb begin
        logic        diag, pz, pneg;
        logic [65:0] qabs;
        n_p2.degen = r_p1.degen;
        for (int l = 0; l < NUM_LANES; l++) begin
            diag = LANE_DIAG[l];
            pz   = (r_p1.pm[l] == 64'd0);
            pneg = !diag && (r_p1.neg[LANE_I[l]] ^ r_p1.neg[LANE_J[l]]) && !pz;
            qabs = {2'b00, r_p1.q[l]} + {65'd0, r_p1.rnz[l] & pneg};
            n_p2.qs[l]   = pneg ? (~qabs + 66'd1) : qabs;
            n_p2.qm[l]   = diag ? (r_p1.r2 - r_p1.pm[l]) : r_p1.pm[l];
            n_p2.qneg[l] = !diag && !pneg && !pz;
        end
    end

    // Angular variance times the bearing factor in two halves.
    always_comb begin
        n_p3.degen = r_p2.degen;
        n_p3.qs    = r_p2.qs;
        n_p3.qneg  = r_p2.qneg;
        for (int l = 0; l < NUM_LANES; l++) begin
            n_p3.alo[l] = r_av * r_p2.qm[l][31:0];
            n_p3.ahi[l] = r_av * r_p2.qm[l][63:32];
        end
    end

    always_comb begin
        n_p4.degen = r_p3.degen;
        n_p4.qs    = r_p3.qs;
        n_p4.qneg  = r_p3.qneg;
        for (int l = 0; l < NUM_LANES; l++) begin
            n_p4.tm[l] = {r_p3.ahi[l], 32'd0} + {32'd0, r_p3.alo[l]};
        end
    end

    // Sum of both terms plus one half of an output step.
    always_comb begin
        logic [97:0] ts;
        n_p5.degen = r_p4.degen;
        for (int l = 0; l < NUM_LANES; l++) begin
            ts = r_p4.qneg[l] ? (~{2'b00, r_p4.tm[l]} + 98'd1) : {2'b00, r_p4.tm[l]};
            n_p5.s[l] = {{32{r_p4.qs[l][65]}}, r_p4.qs[l]} + ts + ROUND_HALF;
        end
    end

    // Drop 32 fraction bits and saturate to the output range.
    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            sh[l] = r_p5.s[l][97:32];
            if (LANE_DIAG[l]) begin
                if (sh[l][65]) begin
                    sat[l] = 48'd0;
                end else if (|sh[l][64:47]) begin
                    sat[l] = {1'b0, SAT_POS47};
                end else begin
                    sat[l] = {1'b0, sh[l][46:0]};
                end
            end else begin
                if (sh[l][65] && !(&sh[l][64:47])) begin
                    sat[l] = SAT_NEG48;
                end else if (!sh[l][65] && (|sh[l][64:47])) begin
                    sat[l] = SAT_POS48;
                end else begin
                    sat[l] = sh[l][47:0];
                end
            end
        end
        if (r_p5.degen) begin
            n_out.cov_xx     = TINY_DIAG;
            n_out.cov_xy     = 48'sd0;
            n_out.cov_xz     = 48'sd0;
            n_out.cov_yy     = TINY_DIAG;
            n_out.cov_yz     = 48'sd0;
            n_out.cov_zz     = TINY_DIAG;
            n_out.degenerate = 1'b1;
        end else begin
            n_out.cov_xx     = sat[0][46:0];
            n_out.cov_xy     = sat[1];
            n_out.cov_xz     = sat[2];
            n_out.cov_yy     = sat[3][46:0];
            n_out.cov_yz     = sat[4];
            n_out.cov_zz     = sat[5][46:0];
            n_out.degenerate = 1'b0;
        end
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_dv    <= '0;
            r_vp1   <= 1'b0;
            r_vp2   <= 1'b0;
            r_vp3   <= 1'b0;
            r_vp4   <= 1'b0;
            r_vp5   <= 1'b0;
            r_out_v <= 1'b0;
        end else if (en) begin
            r_v1    <= i_in_valid;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_dv    <= {r_dv[DIV_STEPS-1:0], r_v3};
            r_vp1   <= r_dv[DIV_STEPS];
            r_vp2   <= r_vp1;
            r_vp3   <= r_vp2;
            r_vp4   <= r_vp3;
            r_vp5   <= r_vp4;
            r_out_v <= r_vp5;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1     <= n_s1;
            r_s2     <= n_s2;
            r_s3     <= n_s3;
            r_div[0] <= n_div0;
            for (int k = 0; k < DIV_STEPS; k++) begin
                r_div[k+1] <= div_step(r_div[k]);
            end
            r_p1  <= n_p1;
            r_p2  <= n_p2;
            r_p3  <= n_p3;
            r_p4  <= n_p4;
            r_p5  <= n_p5;
            r_out <= n_out;
        end
    end

endmodule

// ----- tb/lidar_point_covariance_tb.sv -----
// Testbench for lidar_point_covariance: drives points and register writes, predicts every
// covariance result exactly and checks the results in order under random idling and stalls.
// Depends on lpc_pkg (payload structs, register indexes) and the block's RTL.

// Holds the expected covariance of every accepted point, oldest first, and checks results.
class cov_scoreboard;
    logic [31:0]     range_var;
    logic [31:0]     angle_var;
    lpc_pkg::t_cov   pending_cov[$];
    int unsigned     mismatches;
    int unsigned     results_checked;

    function new();
        range_var       = 32'd429497;
        angle_var       = 32'd4295;
        mismatches      = 0;
        results_checked = 0;
    endfunction

    // One covariance entry, rounded to the Q16.32 grid and saturated.
    function logic [47:0] cov_entry(logic [31:0] mag[3], bit neg[3], logic [63:0] r2,
                                    int i, int j);
        logic [63:0]          pm;
        logic [63:0]          qm;
        bit                   pneg;
        bit                   qneg;
        bit                   diag;
        logic [127:0]         num;
        logic [127:0]         quo;
        logic [127:0]         rmd;
        logic signed [159:0]  acc;
        logic signed [159:0]  ang;
        diag = (i == j);
        pm   = 64'(mag[i]) * 64'(mag[j]);
        pneg = (neg[i] != neg[j]) && (pm != 0);
        // Range term: floor of the signed quotient.
        num  = (128'(range_var) * 128'(pm)) << 32;
        quo  = num / 128'(r2);
        rmd  = num % 128'(r2);
        acc  = {32'b0, quo};
        if (pneg) begin
            acc = -(acc + ((rmd != 0) ? 160'sd1 : 160'sd0));
        end
        // Angular term: r2*I - p*p' scaled by the angle variance.
        qm   = diag ? (r2 - pm) : pm;
        qneg = !diag && !pneg && (pm != 0);
        ang  = {96'b0, 64'(angle_var)} * {96'b0, qm};
        if (qneg) begin
            ang = -ang;
        end
        acc = acc + ang;
        acc = acc + 160'sd2147483648;
        acc = acc >>> 32;
        if (acc < 0) begin
            if (diag) begin
                return 48'd0;
            end
            if (acc < -160'sd140737488355328) begin
                return lpc_pkg::SAT_NEG48;
            end
            return acc[47:0];
        end
        if (acc > 160'sd140737488355327) begin
            return lpc_pkg::SAT_POS48;
        end
        return acc[47:0];
    endfunction

    function void note_point(lpc_pkg::t_point p);
        logic signed [31:0] coord[3];
        logic [31:0]        mag[3];
        bit                 neg[3];
        logic [63:0]        r2;
        lpc_pkg::t_cov      c;
        coord[0] = p.point_x;
        coord[1] = p.point_y;
        coord[2] = p.point_z;
        r2 = 0;
        for (int k = 0; k < 3; k++) begin
            neg[k] = coord[k][31];
            mag[k] = neg[k] ? -coord[k] : coord[k];
            r2 += 64'(mag[k]) * 64'(mag[k]);
        end
        if (r2 == 0) begin
            c = '0;
            c.cov_xx     = lpc_pkg::TINY_DIAG;
            c.cov_yy     = lpc_pkg::TINY_DIAG;
            c.cov_zz     = lpc_pkg::TINY_DIAG;
            c.degenerate = 1'b1;
        end else begin
            c.cov_xx     = 47'(cov_entry(mag, neg, r2, 0, 0));
            c.cov_xy     = cov_entry(mag, neg, r2, 0, 1);
            c.cov_xz     = cov_entry(mag, neg, r2, 0, 2);
            c.cov_yy     = 47'(cov_entry(mag, neg, r2, 1, 1));
            c.cov_yz     = cov_entry(mag, neg, r2, 1, 2);
            c.cov_zz     = 47'(cov_entry(mag, neg, r2, 2, 2));
            c.degenerate = 1'b0;
        end
        pending_cov.push_back(c);
    endfunction

    function void compare_field(string name, logic [47:0] exp_v, logic [47:0] act_v);
        if (exp_v !== act_v) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch on result %0d, %s: expected %h, got %h",
                         results_checked, name, exp_v, act_v);
            end
        end
    endfunction

    function void check_cov(lpc_pkg::t_cov act);
        lpc_pkg::t_cov exp_c;
        if (pending_cov.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("unexpected result with nothing pending: %h", act);
            end
            return;
        end
        exp_c = pending_cov.pop_front();
        compare_field("cov_xx", 48'(exp_c.cov_xx), 48'(act.cov_xx));
        compare_field("cov_xy", exp_c.cov_xy, act.cov_xy);
        compare_field("cov_xz", exp_c.cov_xz, act.cov_xz);
        compare_field("cov_yy", 48'(exp_c.cov_yy), 48'(act.cov_yy));
        compare_field("cov_yz", exp_c.cov_yz, act.cov_yz);
        compare_field("cov_zz", 48'(exp_c.cov_zz), 48'(act.cov_zz));
        compare_field("degenerate", 48'(exp_c.degenerate), 48'(act.degenerate));
        results_checked++;
    endfunction
endclass

module lidar_point_covariance_tb;
    import lpc_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 100;
    localparam int RANDOM_PHASES  = 8;
    localparam int POINTS_PER_PHASE = 77;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        o_in_ready;
    t_point      in_point = '0;
    logic        o_out_valid;
    logic        out_ready = 1'b0;
    t_cov        o_out_cov;
    logic        cfg_we = 1'b0;
    logic        cfg_index = CFG_RANGE_VAR;
    logic [31:0] cfg_data = '0;

    // Idling percentages of the current phase; they are changed only between phases.
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned points_sent = 0;
    int unsigned idle_cycles = 0;
    int unsigned cfg_writes = 0;

    cov_scoreboard sb = new();

    always #6 i_clk = ~i_clk;

    lidar_point_covariance i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_point  (in_point),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_cov   (o_out_cov),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // The receiver decides each cycle whether to take a result. Results are sampled at the
    // edge where valid and ready were both high, before any nonblocking update lands.
    always @(posedge i_clk) begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
        if (i_rst_n && o_out_valid && out_ready) begin
            sb.check_cov(o_out_cov);
        end
    end

    // The watchdog counts cycles in which no channel completes a transaction.
    always @(posedge i_clk) begin
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready) || cfg_we || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired after %0d quiet cycles", idle_cycles);
            $display("lidar_point_covariance_tb: FAIL");
            $finish;
        end
    end

    // Offers one point and returns at the edge where it was accepted. Called on a rising
    // edge; any idle gap is drawn first so that valid is lowered at most once per step.
    task automatic send_point(input t_point p);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 40) begin
            gap++;
        end
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_point <= p;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        sb.note_point(p);
        points_sent++;
    endtask

    // Waits until every expected result has come back and the pipeline has emptied.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.pending_cov.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Writes one variance register; the model copy changes with it. The enable is lowered
    // again before the task returns, so writes can follow one another.
    task automatic write_reg(input logic idx, input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_RANGE_VAR) begin
            sb.range_var = value;
        end else begin
            sb.angle_var = value;
        end
        cfg_writes++;
        @(posedge i_clk);
    endtask

    function automatic t_point make_point(input logic signed [31:0] x, input logic signed [31:0] y,
                                          input logic signed [31:0] z);
        t_point p;
        p.point_x = x;
        p.point_y = y;
        p.point_z = z;
        return p;
    endfunction

    // Coordinates are mostly realistic ranges, with full-width noise and the corner values.
    function automatic logic signed [31:0] rand_coord();
        logic signed [31:0] v;
        case ($urandom_range(5))
            0: v = $urandom;
            1: begin
                case ($urandom_range(5))
                    0: v = 32'sh8000_0000;
                    1: v = 32'sh7fff_ffff;
                    2: v = 32'sd1;
                    3: v = -32'sd1;
                    default: v = 32'sd0;
                endcase
            end
            default: begin
                v = $urandom;
                v = v >>> $urandom_range(8, 28);
            end
        endcase
        return v;
    endfunction

    function automatic logic [31:0] rand_variance();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom >> $urandom_range(8, 30);
            2: return 32'hffff_ffff;
            default: return $urandom_range(1000);
        endcase
    endfunction

    initial begin
        t_point directed[$];
        int unsigned mode;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed points at the reset variances: the degenerate all-zero point, unit
        // steps along each axis, the coordinate extremes and a few ordinary points.
        directed.push_back(make_point(0, 0, 0));
        directed.push_back(make_point(1, 0, 0));
        directed.push_back(make_point(0, -1, 0));
        directed.push_back(make_point(0, 0, 1));
        directed.push_back(make_point(-1, 1, -1));
        directed.push_back(make_point(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000));
        directed.push_back(make_point(-32'sh0002_0000, 32'sh0003_0000, -32'sh0001_0000));
        directed.push_back(make_point(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff));
        directed.push_back(make_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
        directed.push_back(make_point(32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000));
        directed.push_back(make_point(32'sh7fff_ffff, 0, 0));
        directed.push_back(make_point(0, 32'sh8000_0000, 1));
        directed.push_back(make_point(32'sh0064_0000, -32'sh0032_8000, 32'sh0001_4000));
        directed.push_back(make_point(0, 0, 0));
        directed.push_back(make_point(-32'sh00c8_0000, 32'sh00c8_0000, 32'sh0000_0001));
        foreach (directed[k]) begin
            send_point(directed[k]);
        end
        wait_drained();

        // Register extremes on the directed points: both variances at the top, then at zero on six.
        write_reg(CFG_RANGE_VAR, 32'hffff_ffff);
        write_reg(CFG_ANGLE_VAR, 32'hffff_ffff);
        foreach (directed[k]) begin
            send_point(directed[k]);
        end
        wait_drained();
        write_reg(CFG_RANGE_VAR, 32'h0);
        write_reg(CFG_ANGLE_VAR, 32'h0);
        for (int k = 0; k < 6; k++) begin
            send_point(directed[k + 4]);
        end
        wait_drained();

        // Random phases: each one has its own variances and idling pattern, and the
        // pattern cycles through free running, idle sender, stalling receiver and both.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            mode = ph % 4;
            send_idle_pct  = (mode == 1) ? 84 : (mode == 3) ? 16 : 0;
            recv_stall_pct = (mode == 2) ? 84 : (mode == 3) ? 16 : 0;
            write_reg(CFG_RANGE_VAR, (ph == 0) ? 32'd429497 : rand_variance());
            write_reg(CFG_ANGLE_VAR, (ph == 0) ? 32'd4295 : rand_variance());
            for (int n = 0; n < POINTS_PER_PHASE; n++) begin
                if ($urandom_range(49) == 0) begin
                    send_point(make_point(0, 0, 0));
                end else begin
                    send_point(make_point(rand_coord(), rand_coord(), rand_coord()));
                end
            end
            wait_drained();
        end

        $display("covered %0d points and %0d register writes; %0d results checked",
                 points_sent, cfg_writes, sb.results_checked);
        $display("phases ran free, with an idle sender, a stalling receiver, and both");
        if (sb.mismatches == 0 && sb.pending_cov.size() == 0) begin
            $display("lidar_point_covariance_tb: PASS");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.mismatches,
                     sb.pending_cov.size());
            $display("lidar_point_covariance_tb: FAIL");
        end
        $finish;
    end
endmodule
